@@ rtl/apli_pkg.sv @@
// Package for the ADC peak alarm / LED indicator core.
// Holds widths, register indexes and reset values; no dependencies.
package apli_pkg;

	localparam int SampleBits = 10;
	localparam int MaxWindow  = 16;
	localparam int CountBits  = $clog2(MaxWindow);
	localparam int WinBits    = 5;
	localparam int DivBits    = 4;
	localparam int TickBits   = 4;
	localparam int CfgIdxBits = 3;
	localparam int CfgDataBits = 10;

	typedef logic [SampleBits-1:0] sample_t;
	typedef logic [CfgIdxBits-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_LOW_LIMIT   = 3'd0;
	localparam cfg_idx_t REG_HIGH_LIMIT  = 3'd1;
	localparam cfg_idx_t REG_ALARM_THR   = 3'd2;
	localparam cfg_idx_t REG_WINDOW_LEN  = 3'd3;
	localparam cfg_idx_t REG_SLOW_DIVIDE = 3'd4;

	localparam sample_t              LOW_LIMIT_RST   = 10'd10;
	localparam sample_t              HIGH_LIMIT_RST  = 10'd1013;
	localparam sample_t              ALARM_THR_RST   = 10'd500;
	localparam logic [WinBits-1:0]   WINDOW_LEN_RST  = 5'd5;
	localparam logic [DivBits-1:0]   SLOW_DIVIDE_RST = 4'd4;

	// request kinds
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

endpackage

@@ rtl/adc_peak_alarm_led_indicator_core.sv @@
// Top level of the ADC peak alarm / LED indicator core.
// Depends on apli_pkg for widths, register indexes and reset values.
//
// Each request is either an ADC sample or an LED tick and yields exactly one
// result. A request is captured in an input register, evaluated combinationally
// against the window/blink state, and the result lands in an output register
// when that register is empty or is being read out; one request
// is taken every cycle as long as the result side keeps up, since all state
// updates (min/max fold, window close, blink counter) fit in that single
// evaluation stage. Configuration writes are taken one per cycle and belong
// between requests: write registers only while no request is in flight.
module adc_peak_alarm_led_indicator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [apli_pkg::CfgIdxBits-1:0]    cfg_index,
	input  logic [apli_pkg::CfgDataBits-1:0]   cfg_data,
	// requests
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [apli_pkg::SampleBits-1:0]    sample_value,
	// results
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               led_level,
	output logic                               error_flag,
	output logic                               alarm_flag,
	output logic                               window_done,
	output logic [apli_pkg::SampleBits-1:0]    peak_to_peak
);

	localparam int CB = apli_pkg::CountBits;
	localparam int SB = apli_pkg::SampleBits;
	localparam int TB = apli_pkg::TickBits;

	// configuration registers
	apli_pkg::sample_t                  low_limit_q, high_limit_q, alarm_thr_q;
	logic [apli_pkg::WinBits-1:0]       window_len_q;
	logic [apli_pkg::DivBits-1:0]       slow_divide_q;

	// input stage
	logic                    valid_s1;
	logic                    req_type_s1;
	apli_pkg::sample_t       sample_s1;

	// block state
	logic [CB-1:0]           sample_count_q;
	apli_pkg::sample_t       win_min_q, win_max_q;
	logic                    error_q, alarm_q, phase_q, pin_q;
	logic [TB-1:0]           ticks_q;

	// result register
	logic                    out_valid_q;
	logic                    led_q, err_out_q, alarm_out_q, done_q;
	apli_pkg::sample_t       p2p_q;

	logic adv;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q   <= apli_pkg::LOW_LIMIT_RST;
			high_limit_q  <= apli_pkg::HIGH_LIMIT_RST;
			alarm_thr_q   <= apli_pkg::ALARM_THR_RST;
			window_len_q  <= apli_pkg::WINDOW_LEN_RST;
			slow_divide_q <= apli_pkg::SLOW_DIVIDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				apli_pkg::REG_LOW_LIMIT:   low_limit_q   <= cfg_data[SB-1:0];
				apli_pkg::REG_HIGH_LIMIT:  high_limit_q  <= cfg_data[SB-1:0];
				apli_pkg::REG_ALARM_THR:   alarm_thr_q   <= cfg_data[SB-1:0];
				apli_pkg::REG_WINDOW_LEN:  window_len_q  <= cfg_data[apli_pkg::WinBits-1:0];
				apli_pkg::REG_SLOW_DIVIDE: slow_divide_q <= cfg_data[apli_pkg::DivBits-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- evaluation ----------------
	logic [CB:0]        eff_win, seen;
	logic               in_range_err, closes;
	apli_pkg::sample_t  min_nx, max_nx, p2p_nx;
	logic [TB-1:0]      ticks_inc;
	logic               slow_wrap;

	logic [CB-1:0]      count_d;
	apli_pkg::sample_t  min_d, max_d, p2p_d;
	logic               error_d, alarm_d, phase_d, pin_d, done_d;
	logic [TB-1:0]      ticks_d;

	always_comb begin
		// effective window: 0 acts as 1, clamp at MaxWindow
		if (window_len_q == '0)
			eff_win = (CB+1)'(1);
		else if ({1'b0, window_len_q} > (apli_pkg::WinBits+1)'(apli_pkg::MaxWindow))
			eff_win = (CB+1)'(apli_pkg::MaxWindow);
		else
			eff_win = (CB+1)'(window_len_q);

		in_range_err = (sample_s1 < low_limit_q) || (sample_s1 > high_limit_q);
		if (sample_count_q == '0) begin
			min_nx = sample_s1;
			max_nx = sample_s1;
		end else begin
			min_nx = (sample_s1 < win_min_q) ? sample_s1 : win_min_q;
			max_nx = (sample_s1 > win_max_q) ? sample_s1 : win_max_q;
		end
		seen   = {1'b0, sample_count_q} + (CB+1)'(1);
		closes = seen >= eff_win;
		p2p_nx = max_nx - min_nx;

		ticks_inc = ticks_q + TB'(1);
		slow_wrap = ({1'b0, ticks_inc} >= (TB+1)'(slow_divide_q)) || (ticks_inc == '0);

		count_d = sample_count_q;
		min_d   = win_min_q;
		max_d   = win_max_q;
		error_d = error_q;
		alarm_d = alarm_q;
		phase_d = phase_q;
		pin_d   = pin_q;
		ticks_d = ticks_q;
		done_d  = 1'b0;
		p2p_d   = '0;

		if (req_type_s1 == apli_pkg::REQ_SAMPLE) begin
			error_d = in_range_err;
			min_d   = min_nx;
			max_d   = max_nx;
			if (closes) begin
				p2p_d   = p2p_nx;
				alarm_d = p2p_nx > alarm_thr_q;
				done_d  = 1'b1;
				count_d = '0;
			end else begin
				count_d = seen[CB-1:0];
			end
		end else begin
			if (error_q) begin
				phase_d = !phase_q;
				pin_d   = !phase_q;
			end else if (alarm_q) begin
				if (slow_wrap) begin
					phase_d = !phase_q;
					pin_d   = !phase_q;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_inc;
				end
			end else begin
				pin_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			sample_count_q <= '0;
			win_min_q      <= '0;
			win_max_q      <= '0;
			error_q        <= 1'b0;
			alarm_q        <= 1'b0;
			phase_q        <= 1'b0;
			pin_q          <= 1'b0;
			ticks_q        <= '0;
		end else begin
			if (in_valid && in_ready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;

			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (adv) begin
				sample_count_q <= count_d;
				win_min_q      <= min_d;
				win_max_q      <= max_d;
				error_q        <= error_d;
				alarm_q        <= alarm_d;
				phase_q        <= phase_d;
				pin_q          <= pin_d;
				ticks_q        <= ticks_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_type_s1 <= req_type;
			sample_s1   <= sample_value;
		end
		if (adv) begin
			led_q       <= pin_d;
			err_out_q   <= error_d;
			alarm_out_q <= alarm_d;
			done_q      <= done_d;
			p2p_q       <= p2p_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign led_level    = led_q;
	assign error_flag   = err_out_q;
	assign alarm_flag   = alarm_out_q;
	assign window_done  = done_q;
	assign peak_to_peak = p2p_q;

	// ---------------- assertions ----------------
	a_tick_no_window: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_type_s1 == apli_pkg::REQ_TICK |=> out_valid && !window_done
			&& peak_to_peak == '0)
		else $error("tick request produced window data");

	a_off_mode_low: assert property (@(posedge clk) disable iff (!arst_n)
		adv && req_type_s1 == apli_pkg::REQ_TICK && !error_q && !alarm_q |=> !led_level)
		else $error("led not driven low with no flags set");

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_done |-> sample_count_q == '0)
		else $error("window closed but sample count not cleared");

	a_flags_track: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> error_flag == error_q && alarm_flag == alarm_q && led_level == pin_q)
		else $error("result flags differ from block state");

endmodule
